// ===== hw/rtl/rc3_pkg.sv =====
package rc3_pkg;

  localparam int WIN_DIM = 3;
  localparam int TAPS = WIN_DIM * WIN_DIM;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_COEF_FRAC_BITS = 12;
  localparam int COEF_BITS = 16;
  localparam int PROD_BITS = COEF_BITS + 9;
  localparam int SUM_BITS = PROD_BITS + 4;

  localparam logic [2:0] CFG_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_COEF_TOP = 3'd2;
  localparam logic [2:0] CFG_COEF_MID = 3'd3;
  localparam logic [2:0] CFG_COEF_BOT = 3'd4;

  localparam logic [47:0] COEF_RESET = 48'h01C7_01C7_01C7;
  localparam logic [10:0] WIDTH_RESET = 11'd512;
  localparam logic [12:0] HEIGHT_RESET = 13'd512;

  typedef logic [23:0] rgb_t;
  typedef logic [TAPS-1:0][23:0] taps_t;
  typedef logic [WIN_DIM-1:0][47:0] coef_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       run_end;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic valid;
    logic run_end;
    logic frame_end;
  } res_ctl_t;

endpackage

// ===== hw/rtl/rc3_ram.sv =====
module rc3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rc3_tapsel.sv =====
module rc3_tapsel import rc3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             load,
  input  logic [$clog2(MAX_WIDTH)-1:0]     col,
  input  logic [ROW_BITS-1:0]              row,
  input  logic                             last_col,
  input  logic                             last_row,
  input  rgb_t                             top_pix,
  input  rgb_t                             mid_pix,
  input  rgb_t                             bot_pix,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
  input  logic [HEIGHT_BITS-1:0]           h_eff,
  output logic                             free,
  output taps_t                            taps,
  output res_ctl_t                         ctl
);

  localparam int CW = $clog2(MAX_WIDTH);

  rgb_t          win [TAPS];
  logic [3:0]    pend;
  logic [CW-1:0] e_col;
  logic [ROW_BITS-1:0] e_row;

  logic [1:0]    kind;
  logic          issue;
  logic          dx0;
  logic          dy0;
  logic [3:0]    pend_left;
  taps_t         taps_next;

  assign free = ($countones(pend) <= 1);
  assign issue = en && (pend != 4'd0);

  always_comb begin
    kind = 2'd0;
    if (pend[0]) begin
      kind = 2'd0;
    end else if (pend[1]) begin
      kind = 2'd1;
    end else if (pend[2]) begin
      kind = 2'd2;
    end else begin
      kind = 2'd3;
    end
    dx0 = kind[0];
    dy0 = kind[1];
    pend_left = pend & ~(4'd1 << kind);
  end

  always_comb begin
    int px;
    int py;
    int wr;
    int wc;
    for (int ky = 0; ky < WIN_DIM; ky++) begin
      for (int kx = 0; kx < WIN_DIM; kx++) begin
        px = int'(e_col) + kx - 2 + int'(dx0);
        py = int'(e_row) + ky - 2 + int'(dy0);
        wr = ky + int'(dy0);
        wc = kx + int'(dx0);
        if (px >= 0 && px < int'(w_eff) && py >= 0 && py < int'(h_eff)
            && wr < WIN_DIM && wc < WIN_DIM) begin
          taps_next[ky*WIN_DIM+kx] = win[wr*WIN_DIM+wc];
        end else begin
          taps_next[ky*WIN_DIM+kx] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      ctl <= '0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (en) begin
      ctl.valid <= issue;
      ctl.run_end <= (pend_left == 4'd0);
      ctl.frame_end <= (kind == 2'd3);
      taps <= taps_next;
      if (load) begin
        for (int r = 0; r < WIN_DIM; r++) begin
          win[r*WIN_DIM+0] <= win[r*WIN_DIM+1];
          win[r*WIN_DIM+1] <= win[r*WIN_DIM+2];
        end
        win[2] <= top_pix;
        win[5] <= mid_pix;
        win[8] <= bot_pix;
        pend[0] <= (row != '0) && (col != '0);
        pend[1] <= (row != '0) && last_col;
        pend[2] <= last_row && (col != '0);
        pend[3] <= last_row && last_col;
        e_col <= col;
        e_row <= row;
      end else if (issue) begin
        pend <= pend_left;
      end
    end
  end

endmodule

// ===== hw/rtl/rc3_mac.sv =====
module rc3_mac import rc3_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  taps_t      taps,
  input  res_ctl_t   ctl,
  input  coef_t      coef,
  output logic       q_valid,
  output pixel_out_t q
);

  logic signed [PROD_BITS-1:0] prod [3][TAPS];
  res_ctl_t                    m_ctl;
  logic [7:0]                  chan [3];

  always_comb begin
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] shifted;
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum = sum + SUM_BITS'(prod[ch][t]);
      end
      shifted = sum >>> COEF_FRAC_BITS;
      if (sum < 0) begin
        chan[ch] = 8'd0;
      end else if (shifted > SUM_BITS'(255)) begin
        chan[ch] = 8'd255;
      end else begin
        chan[ch] = shifted[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl <= '0;
      q_valid <= 1'b0;
    end else if (en) begin
      m_ctl <= ctl;
      for (int ch = 0; ch < 3; ch++) begin
        for (int t = 0; t < TAPS; t++) begin
          prod[ch][t] <= $signed({1'b0, taps[t][8*ch +: 8]})
                       * $signed(coef[t / WIN_DIM][COEF_BITS*(t % WIN_DIM) +: COEF_BITS]);
        end
      end
      q_valid <= m_ctl.valid;
      q.out_red <= chan[0];
      q.out_green <= chan[1];
      q.out_blue <= chan[2];
      q.run_end <= m_ctl.run_end;
      q.frame_end <= m_ctl.frame_end;
    end
  end

endmodule

// ===== hw/rtl/rgb_conv3x3_zero_pad.sv =====
// 3x3 convolution of an RGB frame with zero padding at the borders.
// Pixels enter on the pix channel in raster order, one beat per pixel;
// filtered pixels leave on the res channel in raster order. A pixel beat
// is taken when pix_valid is high and pix_stall low; res likewise.
// The cfg channel writes width, height and the three kernel rows
// (index 0..4); cfg_ready is always high. Write it only while idle.
// A result is offered once its window's last beat has passed the input,
// window, tap, product, MAC and output registers, later when it queues
// behind other results. One pixel per cycle is accepted; a pixel ending a
// row, or one on the last row, gives two results and the last pixel of a
// frame four, so pix_stall rises while the result sequencer drains them,
// one per cycle. The line rows live in two block RAMs (even and odd rows),
// read at the accepting edge and written in place the same cycle.
// A two-entry output skid absorbs a res_stall; once it fills, the whole
// pipeline holds and pix_stall stays high until res_stall drops.
// Reset clears counters, window and pipeline and restores the default
// 512x512 frame with a box kernel; line RAM content needs no clearing.
module rgb_conv3x3_zero_pad import rc3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  pixel_in_t  pix_data,
  output logic       res_valid,
  input  logic       res_stall,
  output pixel_out_t res_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [10:0]         image_width;
  logic [12:0]         image_height;
  coef_t               coef;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;

  logic [CW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  logic                last_col;
  logic                last_row;
  logic                accept;
  rgb_t                pix_rgb;

  logic                s1_valid;
  rgb_t                s1_pix;
  logic [CW-1:0]       s1_col;
  logic [ROW_BITS-1:0] s1_row;
  logic                s1_last_col;
  logic                s1_last_row;
  logic                s1_fire;

  rgb_t                even_rd;
  rgb_t                odd_rd;
  logic                en;
  logic                e_free;
  taps_t               taps;
  res_ctl_t            tap_ctl;
  logic                q_valid;
  pixel_out_t          q;
  logic                skid_valid;
  pixel_out_t          skid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      coef <= {COEF_RESET, COEF_RESET, COEF_RESET};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:    image_width <= cfg_data[10:0];
        CFG_HEIGHT:   image_height <= cfg_data[12:0];
        CFG_COEF_TOP: coef[0] <= cfg_data;
        CFG_COEF_MID: coef[1] <= cfg_data;
        CFG_COEF_BOT: coef[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HEIGHT_BITS'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = HEIGHT_BITS'(image_height);
    end
  end

  assign last_col = (32'(col) + 1 >= 32'(w_eff));
  assign last_row = (32'(row) + 1 >= 32'(h_eff));
  assign pix_rgb = {pix_data.in_blue, pix_data.in_green, pix_data.in_red};

  assign en = !skid_valid;
  assign s1_fire = s1_valid && en && e_free;
  assign pix_stall = !en || (s1_valid && !e_free);
  assign accept = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        s1_valid <= 1'b1;
        s1_pix <= pix_rgb;
        s1_col <= col;
        s1_row <= row;
        s1_last_col <= last_col;
        s1_last_row <= last_row;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  rc3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_even (
    .clk   (clk),
    .we    (accept && !row[0]),
    .waddr (col),
    .wdata (pix_rgb),
    .re    (accept),
    .raddr (col),
    .rdata (even_rd)
  );

  rc3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_odd (
    .clk   (clk),
    .we    (accept && row[0]),
    .waddr (col),
    .wdata (pix_rgb),
    .re    (accept),
    .raddr (col),
    .rdata (odd_rd)
  );

  rc3_tapsel #(.MAX_WIDTH(MAX_WIDTH)) u_tapsel (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .load     (s1_fire),
    .col      (s1_col),
    .row      (s1_row),
    .last_col (s1_last_col),
    .last_row (s1_last_row),
    .top_pix  (s1_row[0] ? odd_rd : even_rd),
    .mid_pix  (s1_row[0] ? even_rd : odd_rd),
    .bot_pix  (s1_pix),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .free     (e_free),
    .taps     (taps),
    .ctl      (tap_ctl)
  );

  rc3_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .taps    (taps),
    .ctl     (tap_ctl),
    .coef    (coef),
    .q_valid (q_valid),
    .q       (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_data <= skid;
        res_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_data <= q;
        res_valid <= q_valid;
      end
    end else if (q_valid && !skid_valid) begin
      skid <= q;
      skid_valid <= 1'b1;
    end
  end

endmodule
